// File: rtl/core/ddth_pkg.sv
package ddth_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned CordicIters =
    (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int unsigned CordicCntW  = $clog2(CordicIters + 1);
  localparam int unsigned AtanIdxW    = $clog2(AtanEntries);
  localparam int unsigned CordicW     = 27;
  localparam int unsigned ZW          = 32;
  localparam int unsigned AngleW      = 16;
  localparam int unsigned HeadW       = 16;
  localparam int unsigned ThrW        = 15;
  localparam int unsigned SpeedW      = 16;
  localparam int unsigned OutW        = 18;
  localparam int unsigned DsW         = 32;
  localparam int unsigned RootSteps   = 16;
  localparam int unsigned RootCntW    = $clog2(RootSteps + 1);

  localparam logic signed [ZW-1:0] PiQ28     = 32'sd843314857;
  localparam int                   PiQ13     = 25736;
  localparam int                   TwoPiQ13  = 51472;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_HARD = 2'd2
  } turn_mode_e;

  typedef enum logic [1:0] {
    CFG_HARD_THR  = 2'd0,
    CFG_SOFT_THR  = 2'd1,
    CFG_NO_THR    = 2'd2,
    CFG_MAX_SPEED = 2'd3
  } cfg_index_e;

  typedef enum logic {
    DS_SQRT = 1'b0,
    DS_DIV  = 1'b1
  } ds_op_e;

  typedef struct packed {
    logic   start;
    ds_op_e op;
  } ds_req_t;

  // atan(2^-i) in Q.28
  function automatic logic [29:0] atan_q28(input logic [AtanIdxW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd210828714;
      5'd1:    v = 30'd124459457;
      5'd2:    v = 30'd65760959;
      5'd3:    v = 30'd33381290;
      5'd4:    v = 30'd16755422;
      5'd5:    v = 30'd8385879;
      5'd6:    v = 30'd4193963;
      5'd7:    v = 30'd2097109;
      5'd8:    v = 30'd1048571;
      5'd9:    v = 30'd524287;
      5'd10:   v = 30'd262144;
      5'd11:   v = 30'd131072;
      5'd12:   v = 30'd65536;
      5'd13:   v = 30'd32768;
      5'd14:   v = 30'd16384;
      5'd15:   v = 30'd8192;
      5'd16:   v = 30'd4096;
      5'd17:   v = 30'd2048;
      5'd18:   v = 30'd1024;
      5'd19:   v = 30'd512;
      5'd20:   v = 30'd256;
      5'd21:   v = 30'd128;
      5'd22:   v = 30'd64;
      5'd23:   v = 30'd32;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ddth_cordic.sv
module ddth_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ddth_pkg::HeadW-1:0]    x_i,
  input  logic signed [ddth_pkg::HeadW-1:0]    y_i,
  output logic                                 busy_o,
  output logic signed [ddth_pkg::AngleW-1:0]   angle_o
);

  localparam logic signed [17:0] PiA    = 18'(ddth_pkg::PiQ13);
  localparam logic signed [17:0] TwoPiA = 18'(ddth_pkg::TwoPiQ13);

  logic                                   busy_q, busy_d;
  logic [ddth_pkg::CordicCntW-1:0]        cnt_q, cnt_d;
  logic signed [ddth_pkg::CordicW-1:0]    x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ddth_pkg::ZW-1:0]         z_q, z_d, atan_v;
  logic signed [16:0]                     x_ext, y_ext, x_in, y_in;
  logic signed [ddth_pkg::ZW-1:0]         z_in;
  logic signed [ddth_pkg::ZW:0]           z_rnd;
  logic signed [17:0]                     a_raw, a_wrap;

  always_comb begin
    x_ext = {x_i[ddth_pkg::HeadW-1], x_i};
    y_ext = {y_i[ddth_pkg::HeadW-1], y_i};
    if (x_i[ddth_pkg::HeadW-1]) begin
      x_in = -x_ext;
      y_in = -y_ext;
      z_in = y_i[ddth_pkg::HeadW-1] ? -ddth_pkg::PiQ28 : ddth_pkg::PiQ28;
    end else begin
      x_in = x_ext;
      y_in = y_ext;
      z_in = '0;
    end
  end

  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_v = signed'({2'b00, ddth_pkg::atan_q28(ddth_pkg::AtanIdxW'(cnt_q))});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = {{(ddth_pkg::CordicW - 25){x_in[16]}}, x_in, 8'h00};
      y_d    = {{(ddth_pkg::CordicW - 25){y_in[16]}}, y_in, 8'h00};
      z_d    = z_in;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_v;
      end else if (y_q < 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_v;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ddth_pkg::CordicCntW'(ddth_pkg::CordicIters - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // round half up to Q2.13, then wrap into [-pi, pi)
  always_comb begin
    z_rnd = {z_q[ddth_pkg::ZW-1], z_q} + 33'sd16384;
    a_raw = z_rnd[32:15];
    if (a_raw >= PiA) begin
      a_wrap = a_raw - TwoPiA;
    end else if (a_raw < -PiA) begin
      a_wrap = a_raw + TwoPiA;
    end else begin
      a_wrap = a_raw;
    end
  end

  assign angle_o = a_wrap[ddth_pkg::AngleW-1:0];
  assign busy_o  = busy_q;

endmodule

// File: rtl/core/ddth_divsqrt.sv
module ddth_divsqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ddth_pkg::ds_req_t                req_i,
  input  logic [ddth_pkg::DsW-1:0]         operand_i,
  input  logic [ddth_pkg::ThrW-1:0]        divisor_i,
  output logic                             busy_o,
  output logic [ddth_pkg::SpeedW-1:0]      result_o
);

  logic                              busy_q, busy_d;
  logic [ddth_pkg::RootCntW-1:0]     cnt_q, cnt_d;
  ddth_pkg::ds_op_e                  op_q, op_d;
  logic [ddth_pkg::DsW-1:0]          rem_q, rem_d, acc_q, acc_d, bit_q, bit_d;
  logic [ddth_pkg::DsW:0]            lhs, rhs;
  logic [ddth_pkg::DsW+1:0]          diff;
  logic                              ge;

  // shared compare/subtract
  always_comb begin
    if (op_q == ddth_pkg::DS_DIV) begin
      lhs = {16'h0000, rem_q[15:0], acc_q[15]};
      rhs = {18'h00000, divisor_i};
    end else begin
      lhs = {1'b0, rem_q};
      rhs = {1'b0, acc_q} + {1'b0, bit_q};
    end
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge   = !diff[ddth_pkg::DsW+1];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = req_i.op;
      bit_d  = 32'h4000_0000;
      if (req_i.op == ddth_pkg::DS_DIV) begin
        rem_d = {16'h0000, operand_i[31:16]};
        acc_d = {16'h0000, operand_i[15:0]};
      end else begin
        rem_d = operand_i;
        acc_d = '0;
      end
    end else if (busy_q) begin
      if (op_q == ddth_pkg::DS_DIV) begin
        rem_d = ge ? diff[ddth_pkg::DsW-1:0] : lhs[ddth_pkg::DsW-1:0];
        acc_d = {acc_q[ddth_pkg::DsW-2:0], ge};
      end else begin
        if (ge) begin
          rem_d = diff[ddth_pkg::DsW-1:0];
          acc_d = (acc_q >> 1) + bit_q;
        end else begin
          acc_d = acc_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ddth_pkg::RootCntW'(ddth_pkg::RootSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ddth_pkg::DS_SQRT;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    bit_q <= bit_d;
  end

  assign busy_o   = busy_q;
  assign result_o = acc_q[ddth_pkg::SpeedW-1:0];

endmodule

// File: rtl/core/diff_drive_turn_hysteresis.sv
// Differential-drive wheel speeds from a heading vector. One heading (x, y, Q8.8) is
// taken per transfer and yields a result (left/right speed, Q8.8, and the turning mode).
// An iterative CORDIC finds the angle while a shared compare-subtract unit takes the
// square root of x*x + y*y (both 16 iterations, run side by side); in soft turn with a
// nonzero hard threshold the same unit then divides for the wheel factor, another 16
// iterations, so all other items finish sooner. The input is not ready from the transfer
// until the result is loaded into the output register; one finished result can wait
// there while the next heading is taken. Registers: 0 hard, 1 soft, 2 no-turn threshold
// (Q2.13 rad), 3 max speed; write only while idle.
module diff_drive_turn_hysteresis (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ddth_pkg::HeadW-1:0]   heading_x_i,
  input  logic signed [ddth_pkg::HeadW-1:0]   heading_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ddth_pkg::OutW-1:0]    left_speed_o,
  output logic signed [ddth_pkg::OutW-1:0]    right_speed_o,
  output logic [1:0]                          turn_mode_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [15:0]                         cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQX  = 9'b000000010,
    S_SQY  = 9'b000000100,
    S_ROOT = 9'b000001000,
    S_WAIT = 9'b000010000,
    S_MODE = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e                               state_q, state_d;
  logic [ddth_pkg::ThrW-1:0]            hard_q, soft_q, none_q;
  logic [ddth_pkg::SpeedW-1:0]          max_q;
  ddth_pkg::turn_mode_e                 mode_q, mode_d;
  logic signed [ddth_pkg::HeadW-1:0]    hx_q, hy_q;
  logic [ddth_pkg::DsW-1:0]             acc_q, acc_d;
  logic [ddth_pkg::SpeedW-1:0]          base_q;
  logic [ddth_pkg::ThrW-1:0]            num_q, num_d, aa;
  logic                                 pos_q;
  logic                                 out_valid_q;
  logic signed [ddth_pkg::OutW-1:0]     left_q, right_q;
  logic [1:0]                           mode_out_q;

  logic                                 in_fire, out_free;
  logic                                 cor_busy, ds_busy;
  logic signed [ddth_pkg::AngleW-1:0]   angle;
  logic signed [ddth_pkg::AngleW-1:0]   angle_abs;
  logic [ddth_pkg::SpeedW-1:0]          ds_res, base_d;
  ddth_pkg::ds_req_t                    ds_req;
  logic [ddth_pkg::DsW-1:0]             ds_operand;
  logic signed [16:0]                   mul_a, mul_b;
  logic signed [33:0]                   prod;
  logic [15:0]                          num_diff;
  logic signed [ddth_pkg::OutW-1:0]     base18, s1, s2;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  ddth_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .x_i     (heading_x_i),
    .y_i     (heading_y_i),
    .busy_o  (cor_busy),
    .angle_o (angle)
  );

  // S_MUL hands the divide operand over through acc_d
  always_comb begin
    ds_req.start = (state_q == S_ROOT) || (state_q == S_MUL);
    ds_req.op    = (state_q == S_MUL) ? ddth_pkg::DS_DIV : ddth_pkg::DS_SQRT;
    ds_operand   = acc_d;
  end

  ddth_divsqrt u_divsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ds_req),
    .operand_i (ds_operand),
    .divisor_i (hard_q),
    .busy_o    (ds_busy),
    .result_o  (ds_res)
  );

  // shared multiplier: squares, then base * (hard - |a|)
  always_comb begin
    case (state_q)
      S_SQX: begin
        mul_a = {hx_q[ddth_pkg::HeadW-1], hx_q};
        mul_b = {hx_q[ddth_pkg::HeadW-1], hx_q};
      end
      S_SQY: begin
        mul_a = {hy_q[ddth_pkg::HeadW-1], hy_q};
        mul_b = {hy_q[ddth_pkg::HeadW-1], hy_q};
      end
      default: begin
        mul_a = {1'b0, base_q};
        mul_b = {2'b00, num_q};
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    angle_abs = angle[ddth_pkg::AngleW-1] ? -angle : angle;
    aa        = angle_abs[ddth_pkg::ThrW-1:0];
    num_diff  = {1'b0, hard_q} - {1'b0, aa};
    num_d     = num_diff[15] ? '0 : num_diff[ddth_pkg::ThrW-1:0];
    base_d    = (ds_res < max_q) ? ds_res : max_q;
  end

  // mode update with hysteresis, in model order
  always_comb begin
    mode_d = mode_q;
    if (mode_d == ddth_pkg::MODE_HARD && aa <= soft_q) begin
      mode_d = ddth_pkg::MODE_SOFT;
    end
    if (mode_d == ddth_pkg::MODE_SOFT) begin
      if (aa > hard_q) begin
        mode_d = ddth_pkg::MODE_HARD;
      end else if (aa <= none_q) begin
        mode_d = ddth_pkg::MODE_NONE;
      end
    end
    if (mode_d == ddth_pkg::MODE_NONE) begin
      if (aa > hard_q) begin
        mode_d = ddth_pkg::MODE_HARD;
      end else if (aa > none_q) begin
        mode_d = ddth_pkg::MODE_SOFT;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        acc_d   = prod[ddth_pkg::DsW-1:0];
        state_d = S_SQY;
      end
      S_SQY: begin
        acc_d   = acc_q + prod[ddth_pkg::DsW-1:0];
        state_d = S_ROOT;
      end
      S_ROOT: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!cor_busy && !ds_busy) begin
          state_d = S_MODE;
        end
      end
      S_MODE: begin
        if (mode_d == ddth_pkg::MODE_SOFT && hard_q != '0) begin
          state_d = S_MUL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        acc_d   = prod[ddth_pkg::DsW-1:0] + {18'h00000, hard_q[ddth_pkg::ThrW-1:1]};
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!ds_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    base18 = {2'b00, base_q};
    case (mode_q)
      ddth_pkg::MODE_SOFT: begin
        s1 = (hard_q == '0) ? base18 : {2'b00, ds_res};
        s2 = (base18 <<< 1) - s1;
      end
      ddth_pkg::MODE_HARD: begin
        s1 = -{2'b00, max_q};
        s2 = {2'b00, max_q};
      end
      default: begin
        s1 = base18;
        s2 = base18;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= ddth_pkg::MODE_NONE;
      out_valid_q <= 1'b0;
      hard_q      <= 15'd19302;
      soft_q      <= 15'd12868;
      none_q      <= 15'd1430;
      max_q       <= 16'd2560;
    end else begin
      state_q <= state_d;
      if (state_q == S_MODE) begin
        mode_q <= mode_d;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ddth_pkg::CFG_HARD_THR:  hard_q <= cfg_data_i[ddth_pkg::ThrW-1:0];
          ddth_pkg::CFG_SOFT_THR:  soft_q <= cfg_data_i[ddth_pkg::ThrW-1:0];
          ddth_pkg::CFG_NO_THR:    none_q <= cfg_data_i[ddth_pkg::ThrW-1:0];
          ddth_pkg::CFG_MAX_SPEED: max_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_fire) begin
      hx_q <= heading_x_i;
      hy_q <= heading_y_i;
    end
    if (state_q == S_MODE) begin
      base_q <= base_d;
      num_q  <= num_d;
      pos_q  <= !angle[ddth_pkg::AngleW-1] && (angle != '0);
    end
    if (state_q == S_DONE && out_free) begin
      left_q     <= pos_q ? s1 : s2;
      right_q    <= pos_q ? s2 : s1;
      mode_out_q <= mode_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign turn_mode_o   = mode_out_q;

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!cor_busy && !ds_busy))
    else $error("units busy while idle");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready right after a transfer");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_o)
    else $error("result not presented");

  a_hard_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && turn_mode_o == ddth_pkg::MODE_HARD) |-> (left_speed_o == -right_speed_o))
    else $error("hard turn wheels not opposite");

  a_none_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && turn_mode_o == ddth_pkg::MODE_NONE) |-> (left_speed_o == right_speed_o))
    else $error("straight drive wheels differ");

endmodule
